@@ hw/rtl/vzd_pkg.sv @@
// shared types, codes and functions for the varint zigzag decoder
package vzd_pkg;

  localparam int unsigned VZD_QUEUE_DEPTH = 4;
  localparam int unsigned MAX_BYTES       = 10;

  localparam logic [1:0] KIND_U64  = 2'd0;
  localparam logic [1:0] KIND_ZZ32 = 2'd1;
  localparam logic [1:0] KIND_ZZ64 = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
  localparam logic [1:0] STATUS_EXCEEDS32 = 2'd2;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

  typedef enum logic [1:0] {
    JOB_VALUE,
    JOB_TOO_LONG,
    JOB_TOO_SHORT
  } job_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [3:0]  bytes_used;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  used;
    job_kind_t   kind;
  } job_t;

  function automatic logic [63:0] zigzag64(input logic [63:0] u);
    return (u >> 1) ^ {64{u[0]}};
  endfunction

  function automatic logic [63:0] zigzag32(input logic [63:0] v);
    logic [31:0] r;
    r = (v[31:0] >> 1) ^ {32{v[0]}};
    return {{32{r[31]}}, r};
  endfunction

endpackage

@@ hw/rtl/vzd_front.sv @@
// front end: gathers payload bytes and hands finished or failed values to the queue
module vzd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  vzd_pkg::in_beat_t in_beat,
  output logic            job_push,
  output vzd_pkg::job_t   job
);
  import vzd_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [5:0]  sh;
  logic [63:0] acc_new;
  logic [3:0]  used;

  assign sh      = 6'(idx_r * 7);
  assign acc_new = acc_r | ({57'd0, in_beat.data_byte[6:0]} << sh);
  assign used    = idx_r + 4'd1;

  always_comb begin
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    job_push = 1'b0;
    job.acc  = acc_new;
    job.used = used;
    job.kind = JOB_VALUE;
    if (accept) begin
      if (in_beat.flush) begin
        job.used = idx_r;
        job.kind = JOB_TOO_SHORT;
        if (idx_r != 4'd0) begin
          job_push = 1'b1;
          acc_nxt  = '0;
          idx_nxt  = '0;
        end
      end else if (in_beat.data_byte[7]) begin
        if (used >= 4'(MAX_BYTES)) begin
          job.kind = JOB_TOO_LONG;
          job_push = 1'b1;
          acc_nxt  = '0;
          idx_nxt  = '0;
        end else begin
          acc_nxt = acc_new;
          idx_nxt = used;
        end
      end else begin
        job_push = 1'b1;
        acc_nxt  = '0;
        idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hw/rtl/vzd_queue.sv @@
// short job queue between front end and back end
module vzd_queue #(
  parameter int unsigned Depth = vzd_pkg::VZD_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vzd_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output vzd_pkg::job_t rd_data
);
  import vzd_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(Depth));
  assign valid   = (cnt_r != '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/vzd_back.sv @@
// back end: zigzag decode, range check and the output register
module vzd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         value_kind,
  input  logic               job_valid,
  input  vzd_pkg::job_t      job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output vzd_pkg::out_beat_t out_beat
);
  import vzd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r;
  out_beat_t res;

  always_comb begin
    res.bytes_used    = job.used;
    res.decoded_value = '0;
    res.status        = STATUS_OK;
    unique case (job.kind)
      JOB_TOO_LONG:  res.status = STATUS_TOO_LONG;
      JOB_TOO_SHORT: res.status = STATUS_TOO_SHORT;
      default: begin
        unique case (value_kind)
          KIND_ZZ32: begin
            if (job.acc[63:32] != 32'd0) begin
              res.status = STATUS_EXCEEDS32;
            end else begin
              res.decoded_value = zigzag32(job.acc);
            end
          end
          KIND_ZZ64: res.decoded_value = zigzag64(job.acc);
          default:   res.decoded_value = job.acc;
        endcase
      end
    endcase
  end

  assign job_pop = job_valid && (!out_valid_r || pop);
  assign empty   = !out_valid_r;
  assign out_beat = out_beat_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (job_pop) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      out_beat_r <= res;
    end
  end

endmodule

@@ hw/rtl/varint_zigzag_decoder.sv @@
// Base-128 varint decoder with zigzag signed modes. One byte beat is taken every cycle while
// full is low; the front end folds each byte into the accumulator in that same cycle and, on
// a final byte, a ten-byte overrun or a flush over a partial value, writes one job into a
// QueueDepth-entry queue. The back end decodes the head job into the output register, so a
// result reaches the out ports from the output register; results drain at one per cycle while
// pop is held and a job waits. full rises only when the queue is full, which happens when the
// consumer stops popping. value_kind is sampled by the back end and must only change while idle.
module varint_zigzag_decoder #(
  parameter int unsigned QueueDepth = vzd_pkg::VZD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  vzd_pkg::in_beat_t  in_beat,
  output logic               empty,
  input  logic               pop,
  output vzd_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data
);
  import vzd_pkg::*;

  logic [1:0] kind_r;
  logic       accept;
  logic       job_push;
  job_t       job_in;
  logic       job_valid;
  job_t       job_out;
  logic       job_pop;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_U64;
    end else if (cfg_we) begin
      kind_r <= cfg_data;
    end
  end

  vzd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_beat  (in_beat),
    .job_push (job_push),
    .job      (job_in)
  );

  vzd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .full    (full),
    .pop     (job_pop),
    .valid   (job_valid),
    .rd_data (job_out)
  );

  vzd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .value_kind (kind_r),
    .job_valid  (job_valid),
    .job        (job_out),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .out_beat   (out_beat)
  );

  // error beats carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_beat.status != STATUS_OK) |-> out_beat.decoded_value == 64'd0)
    else $error("error beat with nonzero value");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_beat.bytes_used >= 4'd1 && out_beat.bytes_used <= 4'd10))
    else $error("bytes_used out of range");

  a_exceeds_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_beat.status == STATUS_EXCEEDS32) |-> kind_r == KIND_ZZ32)
    else $error("32-bit overflow outside zigzag 32 mode");

endmodule

@@ tb/tb_varint_zigzag_decoder.sv @@
// self-checking testbench for the varint zigzag decoder: directed table, then random byte streams
module tb_varint_zigzag_decoder;
  import vzd_pkg::*;

  localparam logic [1:0]  KIND_SPARE = 2'd3;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          NDIR       = 33;
  localparam int          HOLD_LEN   = 300;
  localparam int          PHASE_ITEMS = 100;

  typedef struct packed {
    logic [1:0] kind;
    in_beat_t   beat;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  // a typed row carries its result, the other rows are predicted
  dir_row_t dir_tab [NDIR] = '{
    '{KIND_U64,  '{8'h00, 1'b1}, 1'b0, '0},
    '{KIND_U64,  '{8'h7F, 1'b0}, 1'b1, '{64'd127, 4'd1, STATUS_OK}},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'hFF, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'hFF, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'hFF, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'hFF, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'h7F, 1'b0}, 1'b1, '{ALL_ONES, 4'd10, STATUS_OK}},
    '{KIND_U64,  '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_U64, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b0}, 1'b1, '{64'd0, 4'd10, STATUS_TOO_LONG}},
    '{KIND_U64,  '{8'h81, 1'b0}, 1'b0, '0},
    '{KIND_U64,  '{8'hFF, 1'b1}, 1'b1, '{64'd0, 4'd1, STATUS_TOO_SHORT}},
    '{KIND_ZZ32, '{8'h01, 1'b0}, 1'b1, '{ALL_ONES, 4'd1, STATUS_OK}},
    '{KIND_ZZ32, '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_ZZ32, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_ZZ32, '{8'h80, 1'b0}, 1'b0, '0}, '{KIND_ZZ32, '{8'h80, 1'b0}, 1'b0, '0},
    '{KIND_ZZ32, '{8'h10, 1'b0}, 1'b1, '{64'd0, 4'd5, STATUS_EXCEEDS32}},
    '{KIND_ZZ64, '{8'h02, 1'b0}, 1'b1, '{64'd1, 4'd1, STATUS_OK}},
    '{KIND_SPARE, '{8'h85, 1'b0}, 1'b0, '0},
    '{KIND_SPARE, '{8'h03, 1'b0}, 1'b0, '0}
  };

  int send_idle [4] = '{0, 83, 0, 32};
  int recv_stall [4] = '{0, 0, 83, 32};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_beat_t  in_beat = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_data = KIND_U64;

  logic [63:0] acc = '0;
  logic [3:0]  nbytes = '0;
  logic [1:0]  kind = KIND_U64;

  out_beat_t pending_results [$];
  int mismatches = 0;
  int items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  varint_zigzag_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_beat  (in_beat),
    .empty    (empty),
    .pop      (pop),
    .out_beat (out_beat),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit decode_byte(input in_beat_t b, output out_beat_t r);
    logic [3:0]  used;
    logic [31:0] half;
    r = '0;
    if (b.flush) begin
      if (nbytes == 0) return 1'b0;
      r.bytes_used = nbytes;
      r.status = STATUS_TOO_SHORT;
      acc = '0;
      nbytes = '0;
      return 1'b1;
    end
    acc = acc | ({57'd0, b.data_byte[6:0]} << (7 * nbytes));
    used = nbytes + 4'd1;
    if (b.data_byte[7]) begin
      if (used < MAX_BYTES) begin
        nbytes = used;
        return 1'b0;
      end
      r.status = STATUS_TOO_LONG;
    end else if (kind == KIND_ZZ32) begin
      if (acc[63:32] != 32'd0) begin
        r.status = STATUS_EXCEEDS32;
      end else begin
        half = {1'b0, acc[31:1]} ^ {32{acc[0]}};
        r.decoded_value = {{32{half[31]}}, half};
      end
    end else if (kind == KIND_ZZ64) begin
      r.decoded_value = {1'b0, acc[63:1]} ^ {64{acc[0]}};
    end else begin
      r.decoded_value = acc;
    end
    r.bytes_used = used;
    acc = '0;
    nbytes = '0;
    return 1'b1;
  endfunction

  task automatic push_byte(input in_beat_t b, input logic typed, input out_beat_t want);
    int gap;
    out_beat_t res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (!(b.flush && nbytes == 0)) items++;
    if (decode_byte(b, res) || typed) pending_results.push_back(typed ? want : res);
  endtask

  task automatic write_kind(input logic [1:0] k);
    @(negedge clk) push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= k;
    @(negedge clk) cfg_we <= 1'b0;
    kind = k;
  endtask

  task automatic push_random_value();
    int r;
    int len;
    logic [6:0] p;
    r = $urandom_range(99);
    if (r < 75) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(10, 6) : $urandom_range(5, 1);
      for (int i = 0; i < len; i++) begin
        p = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 7'h7F : 7'h00)
                                     : 7'($urandom_range(127));
        push_byte('{{(i < len - 1), p}, 1'b0}, 1'b0, '0);
      end
    end else if (r < 83) begin
      repeat (10) push_byte('{{1'b1, 7'($urandom_range(127))}, 1'b0}, 1'b0, '0);
    end else if (r < 91) begin
      len = $urandom_range(9, 1);
      repeat (len) push_byte('{{1'b1, 7'($urandom_range(127))}, 1'b0}, 1'b0, '0);
      push_byte('{8'($urandom_range(255)), 1'b1}, 1'b0, '0);
    end else if (r < 96) begin
      push_byte('{8'($urandom_range(255)), 1'b1}, 1'b0, '0);
    end else begin
      push_byte('{8'($urandom_range(255)), 1'($urandom_range(1))}, 1'b0, '0);
    end
  endtask

  // receiver side, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      pop <= 1'b0;
      hold_left <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_beat
    out_beat_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_beat);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_beat.decoded_value !== want.decoded_value) begin
          $error("decoded_value expected %h got %h", want.decoded_value, out_beat.decoded_value);
          mismatches++;
        end
        if (out_beat.bytes_used !== want.bytes_used) begin
          $error("bytes_used expected %0d got %0d", want.bytes_used, out_beat.bytes_used);
          mismatches++;
        end
        if (out_beat.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_beat.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_kind(KIND_U64);

    for (int i = 0; i < NDIR; i++) begin
      if (dir_tab[i].kind != kind) write_kind(dir_tab[i].kind);
      push_byte(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    end

    // fill the queue while the receiver holds off
    write_kind(KIND_U64);
    holds_asked++;
    repeat (40) push_byte('{{1'b0, 7'($urandom_range(127))}, 1'b0}, 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 4; k++) begin
        write_kind(2'(k));
        send_idle_pct = send_idle[ph];
        recv_stall_pct = recv_stall[ph];
        items = 0;
        while (items < PHASE_ITEMS) push_random_value();
      end
    end

    @(negedge clk) push <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
